// ===== rtl/text_console_writer_core_assert.svh =====
// Assertion macros shared by the console RTL.
`ifndef TEXT_CONSOLE_WRITER_CORE_ASSERT_SVH
`define TEXT_CONSOLE_WRITER_CORE_ASSERT_SVH

// The consequent must hold in the same cycle as the antecedent.
`define TCW_ASSERT_IMP(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define TCW_ASSERT_NXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== rtl/tcw_pkg.sv =====
package tcw_pkg;

    localparam int COLUMNS     = 80;
    localparam int ROWS        = 25;
    localparam int CELL_COUNT  = COLUMNS * ROWS;
    localparam int ADDR_W      = $clog2(CELL_COUNT);
    localparam int CELL_W      = $clog2(CELL_COUNT + 1);
    localparam int COL_W       = $clog2(COLUMNS);
    localparam int CURSOR_W    = 11;
    localparam int CHAR_W      = 8;
    localparam int ATTR_W      = 8;
    localparam int DATA_W      = CHAR_W + ATTR_W;
    localparam int CFG_ADDR_W  = 3;

    localparam logic [CHAR_W-1:0] NEWLINE_CODE    = 8'd10;
    localparam int                NEWLINE_INDENT  = 4;
    localparam logic [ATTR_W-1:0] RESET_ATTRIBUTE = 8'd15;

    localparam logic REG_DEFAULT_ATTRIBUTE = 1'b0;

    typedef enum logic {
        CMD_PRINT = 1'b0,
        CMD_READ  = 1'b1
    } tcw_cmd_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_EXEC,
        ST_SHIFT,
        ST_BLANK
    } tcw_state_t;

    typedef struct packed {
        logic              en;
        logic [ADDR_W-1:0] addr;
        logic [DATA_W-1:0] data;
    } tcw_ram_wr_t;

endpackage

// ===== rtl/tcw_screen_ram.sv =====
module tcw_screen_ram
    import tcw_pkg::*;
(
    input  logic              clk,
    input  tcw_ram_wr_t       wr,
    input  logic              rd_en,
    input  logic [ADDR_W-1:0] rd_addr,
    output logic [DATA_W-1:0] rd_data
);

    logic [DATA_W-1:0] mem [CELL_COUNT];

    always_ff @(posedge clk)
    begin
        if (wr.en)
        begin
            mem[wr.addr] <= wr.data;
        end
    end

    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule

// ===== rtl/text_console_writer_core.sv =====
// Text console with an 80 by 25 screen store. A print or read command is taken when start
// is high and busy is low, and its result beat appears on the result ports with done high
// for exactly one cycle, registered from the execute state (for a scrolling print, from the
// end of the blank state); the receiver cannot stall it and must capture it in that cycle.
// A print that moves the cursor past the last cell scrolls the screen: the sequencer
// walks the store once through its single write port and one read port, copying every
// cell up one row and then blanking the last row. After reset the store is cleared one
// cell per cycle, and busy stays high until the whole store is cleared.
// The default attribute register may be written over the APB port at any idle time.
module text_console_writer_core
    import tcw_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  start,
    output logic                  busy,
    input  logic                  command,
    input  logic [CHAR_W-1:0]     character,
    input  logic signed [7:0]     column,
    input  logic signed [5:0]     screen_row,
    input  logic [ATTR_W-1:0]     attribute,
    output logic                  done,
    output logic [CURSOR_W-1:0]   cursor_position,
    output logic                  scrolled,
    output logic [CHAR_W-1:0]     cell_character,
    output logic [ATTR_W-1:0]     cell_attribute,
    input  logic                  psel,
    input  logic                  penable,
    input  logic                  pwrite,
    input  logic [CFG_ADDR_W-1:0] paddr,
    input  logic [31:0]           pwdata,
    output logic [31:0]           prdata,
    output logic                  pready
);

    tcw_state_t          state_reg, state_next;
    logic [CELL_W-1:0]   cnt_reg, cnt_next;
    logic                scrolling_reg, scrolling_next;
    logic [CELL_W-1:0]   cursor_base_reg, cursor_base_next;
    logic [COL_W-1:0]    cursor_col_reg, cursor_col_next;
    logic [ATTR_W-1:0]   def_attr_reg;
    logic                done_reg, done_next;
    logic [CURSOR_W-1:0] out_cursor_reg, out_cursor_next;
    logic                out_scrolled_reg, out_scrolled_next;
    logic [CHAR_W-1:0]   out_char_reg, out_char_next;
    logic [ATTR_W-1:0]   out_attr_reg, out_attr_next;

    tcw_cmd_t            cmd_reg;
    logic [CHAR_W-1:0]   ch_reg;
    logic [ATTR_W-1:0]   attr_reg;
    logic                valid_reg;
    logic [ADDR_W-1:0]   cell_reg;
    logic [CELL_W-1:0]   tbase_reg;
    logic [COL_W-1:0]    tcol_reg;

    logic                accept;
    logic                use_cursor;
    logic [6:0]          col_u;
    logic [4:0]          row_u;
    logic                in_valid;
    logic [CELL_W-1:0]   in_base;
    logic [COL_W-1:0]    in_col;
    logic [ADDR_W-1:0]   in_cell;
    logic [ATTR_W-1:0]   eff_attr;

    logic                is_newline;
    logic                last_col;
    logic [CELL_W-1:0]   new_base;
    logic [COL_W-1:0]    new_col;
    logic                wrap;
    logic [CELL_W-1:0]   fin_base;

    tcw_ram_wr_t         ram_wr;
    logic                ram_rd_en;
    logic [ADDR_W-1:0]   ram_rd_addr;
    logic [DATA_W-1:0]   ram_rd_data;

    tcw_screen_ram u_ram (
        .clk     (clk),
        .wr      (ram_wr),
        .rd_en   (ram_rd_en),
        .rd_addr (ram_rd_addr),
        .rd_data (ram_rd_data)
    );

    assign busy            = (state_reg != ST_IDLE);
    assign accept          = start && !busy;
    assign done            = done_reg;
    assign cursor_position = out_cursor_reg;
    assign scrolled        = out_scrolled_reg;
    assign cell_character  = out_char_reg;
    assign cell_attribute  = out_attr_reg;
    assign pready          = 1'b1;
    assign prdata          = (paddr[2] == REG_DEFAULT_ATTRIBUTE) ? 32'(def_attr_reg) : '0;

    assign use_cursor = column[7] | screen_row[5];
    assign col_u      = column[6:0];
    assign row_u      = screen_row[4:0];
    assign in_valid   = use_cursor || ((32'(col_u) < 32'(COLUMNS)) && (32'(row_u) < 32'(ROWS)));
    assign in_base    = use_cursor ? cursor_base_reg : CELL_W'(32'(row_u) * COLUMNS);
    assign in_col     = use_cursor ? cursor_col_reg : COL_W'(col_u);
    assign in_cell    = ADDR_W'(in_base + CELL_W'(in_col));
    assign eff_attr   = (attribute == '0) ? def_attr_reg : attribute;

    assign is_newline = (ch_reg == NEWLINE_CODE);
    assign last_col   = (tcol_reg == COL_W'(COLUMNS - 1));
    assign new_base   = (is_newline || last_col) ? tbase_reg + CELL_W'(COLUMNS) : tbase_reg;
    assign new_col    = is_newline ? COL_W'(NEWLINE_INDENT)
                      : (last_col ? '0 : tcol_reg + COL_W'(1));
    assign wrap       = (new_base == CELL_W'(CELL_COUNT));
    assign fin_base   = wrap ? CELL_W'(CELL_COUNT - COLUMNS) : new_base;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg        <= ST_BLANK;
            cnt_reg          <= '0;
            scrolling_reg    <= 1'b0;
            cursor_base_reg  <= '0;
            cursor_col_reg   <= '0;
            done_reg         <= 1'b0;
            out_cursor_reg   <= '0;
            out_scrolled_reg <= 1'b0;
            out_char_reg     <= '0;
            out_attr_reg     <= '0;
        end
        else
        begin
            state_reg        <= state_next;
            cnt_reg          <= cnt_next;
            scrolling_reg    <= scrolling_next;
            cursor_base_reg  <= cursor_base_next;
            cursor_col_reg   <= cursor_col_next;
            done_reg         <= done_next;
            out_cursor_reg   <= out_cursor_next;
            out_scrolled_reg <= out_scrolled_next;
            out_char_reg     <= out_char_next;
            out_attr_reg     <= out_attr_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            def_attr_reg <= RESET_ATTRIBUTE;
        end
        else if (psel && penable && pwrite && pready && (paddr[2] == REG_DEFAULT_ATTRIBUTE))
        begin
            def_attr_reg <= pwdata[ATTR_W-1:0];
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            cmd_reg   <= tcw_cmd_t'(command);
            ch_reg    <= character;
            attr_reg  <= eff_attr;
            valid_reg <= in_valid;
            cell_reg  <= in_cell;
            tbase_reg <= in_base;
            tcol_reg  <= in_col;
        end
    end

    always_comb
    begin
        state_next        = state_reg;
        cnt_next          = cnt_reg;
        scrolling_next    = scrolling_reg;
        cursor_base_next  = cursor_base_reg;
        cursor_col_next   = cursor_col_reg;
        done_next         = 1'b0;
        out_cursor_next   = out_cursor_reg;
        out_scrolled_next = out_scrolled_reg;
        out_char_next     = out_char_reg;
        out_attr_next     = out_attr_reg;
        ram_wr.en         = 1'b0;
        ram_wr.addr       = cell_reg;
        ram_wr.data       = {attr_reg, ch_reg};
        ram_rd_en         = 1'b0;
        ram_rd_addr       = in_cell;

        unique case (state_reg)
            ST_IDLE:
            begin
                ram_rd_en = start;
                if (accept)
                begin
                    state_next = ST_EXEC;
                end
            end

            ST_EXEC:
            begin
                out_cursor_next   = CURSOR_W'(cursor_base_reg + CELL_W'(cursor_col_reg));
                out_scrolled_next = 1'b0;
                out_char_next     = '0;
                out_attr_next     = '0;
                state_next        = ST_IDLE;
                done_next         = 1'b1;
                if (cmd_reg == CMD_READ)
                begin
                    if (valid_reg)
                    begin
                        out_char_next = ram_rd_data[CHAR_W-1:0];
                        out_attr_next = ram_rd_data[DATA_W-1:CHAR_W];
                    end
                end
                else if (valid_reg)
                begin
                    ram_wr.en         = !is_newline;
                    cursor_base_next  = fin_base;
                    cursor_col_next   = new_col;
                    out_cursor_next   = CURSOR_W'(fin_base + CELL_W'(new_col));
                    out_scrolled_next = wrap;
                    if (wrap)
                    begin
                        state_next     = ST_SHIFT;
                        done_next      = 1'b0;
                        cnt_next       = '0;
                        scrolling_next = 1'b1;
                    end
                end
            end

            ST_SHIFT:
            begin
                ram_rd_en   = (cnt_reg < CELL_W'(CELL_COUNT - COLUMNS));
                ram_rd_addr = ADDR_W'(cnt_reg + CELL_W'(COLUMNS));
                ram_wr.en   = (cnt_reg != '0);
                ram_wr.addr = ADDR_W'(cnt_reg - CELL_W'(1));
                ram_wr.data = ram_rd_data;
                if (cnt_reg == CELL_W'(CELL_COUNT - COLUMNS))
                begin
                    state_next = ST_BLANK;
                end
                else
                begin
                    cnt_next = cnt_reg + CELL_W'(1);
                end
            end

            ST_BLANK:
            begin
                ram_wr.en   = 1'b1;
                ram_wr.addr = ADDR_W'(cnt_reg);
                ram_wr.data = '0;
                cnt_next    = cnt_reg + CELL_W'(1);
                if (cnt_reg == CELL_W'(CELL_COUNT - 1))
                begin
                    state_next     = ST_IDLE;
                    done_next      = scrolling_reg;
                    scrolling_next = 1'b0;
                end
            end

            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

`include "text_console_writer_core_assert.svh"

    `TCW_ASSERT_NXT(a_accept_busy, accept, busy, "Accepted command did not raise busy.")
    `TCW_ASSERT_IMP(a_cursor_range, 1'b1, (cursor_base_reg < CELL_W'(CELL_COUNT)) && (32'(cursor_col_reg) < COLUMNS), "Cursor left the screen.")
    `TCW_ASSERT_IMP(a_scroll_row, done && scrolled, cursor_base_reg == CELL_W'(CELL_COUNT - COLUMNS), "Scroll did not leave the cursor on the last row.")
    `TCW_ASSERT_NXT(a_done_single, done, !done, "Result strobe held for more than one cycle.")

endmodule

// ===== tb/text_console_writer_core_checker.sv =====
module text_console_writer_core_checker
    import tcw_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  start,
    input  logic                  busy,
    input  logic                  command,
    input  logic [CHAR_W-1:0]     character,
    input  logic signed [7:0]     column,
    input  logic signed [5:0]     screen_row,
    input  logic [ATTR_W-1:0]     attribute,
    input  logic                  done,
    input  logic [CURSOR_W-1:0]   cursor_position,
    input  logic                  scrolled,
    input  logic [CHAR_W-1:0]     cell_character,
    input  logic [ATTR_W-1:0]     cell_attribute,
    input  logic                  psel,
    input  logic                  penable,
    input  logic                  pwrite,
    input  logic [CFG_ADDR_W-1:0] paddr,
    input  logic [31:0]           pwdata,
    input  logic [31:0]           prdata,
    input  logic                  pready,
    output int                    failures,
    output int                    pending,
    output int                    beats,
    output int                    scroll_beats,
    output int                    read_beats
);

    typedef struct packed {
        logic [CURSOR_W-1:0] cursor;
        logic                scrolled;
        logic [CHAR_W-1:0]   ch;
        logic [ATTR_W-1:0]   attr;
    } console_result_t;

    localparam logic [CFG_ADDR_W-1:0] ATTR_REG_ADDR = CFG_ADDR_W'(4 * REG_DEFAULT_ATTRIBUTE);

    logic [DATA_W-1:0] screen_model [CELL_COUNT];
    int unsigned       cursor_model;
    logic [ATTR_W-1:0] default_attr;
    console_result_t   expected_beats [$];
    int                fail_count = 0;
    int                beat_count = 0;
    int                scroll_count = 0;
    int                read_count = 0;

    task automatic report_mismatch(input string what);
        $display("%0t: %s", $time, what);
        fail_count++;
    endtask

    task automatic run_console_command(
        input  tcw_cmd_t             cmd,
        input  logic [CHAR_W-1:0]    ch,
        input  logic signed [7:0]    col,
        input  logic signed [5:0]    row,
        input  logic [ATTR_W-1:0]    attr,
        output console_result_t      res
    );
        int   cell_idx;
        logic in_range;
        logic [ATTR_W-1:0] attr_used;
        res = '0;
        cell_idx = 0;
        in_range = 1'b1;
        attr_used = attr;
        if (col >= 0 && row >= 0)
        begin
            if (col >= COLUMNS || row >= ROWS)
                in_range = 1'b0;
            else
                cell_idx = int'(row) * COLUMNS + int'(col);
        end
        else
        begin
            cell_idx = int'(cursor_model);
            if (cursor_model >= CELL_COUNT)
                in_range = 1'b0;
        end
        if (cmd == CMD_READ)
        begin
            if (in_range)
            begin
                res.ch = screen_model[cell_idx][CHAR_W-1:0];
                res.attr = screen_model[cell_idx][DATA_W-1:CHAR_W];
            end
        end
        else if (in_range)
        begin
            if (attr_used == '0)
                attr_used = default_attr;
            if (ch == NEWLINE_CODE)
                cursor_model = (cell_idx / COLUMNS + 1) * COLUMNS + NEWLINE_INDENT;
            else
            begin
                screen_model[cell_idx] = {attr_used, ch};
                cursor_model = cell_idx + 1;
            end
            if (cursor_model >= CELL_COUNT)
            begin
                for (int i = 0; i < CELL_COUNT - COLUMNS; i++)
                    screen_model[i] = screen_model[i + COLUMNS];
                for (int i = CELL_COUNT - COLUMNS; i < CELL_COUNT; i++)
                    screen_model[i] = '0;
                cursor_model = cursor_model - COLUMNS;
                res.scrolled = 1'b1;
            end
        end
        res.cursor = cursor_model[CURSOR_W-1:0];
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        console_result_t want;
        if (!rst_n)
        begin
            for (int i = 0; i < CELL_COUNT; i++)
                screen_model[i] = '0;
            cursor_model = 0;
            default_attr = RESET_ATTRIBUTE;
            expected_beats.delete();
        end
        else
        begin
            if (done)
            begin
                if (expected_beats.size() == 0)
                    report_mismatch("result beat with no command outstanding");
                else
                begin
                    want = expected_beats.pop_front();
                    beat_count++;
                    if (want.scrolled)
                        scroll_count++;
                    if (cursor_position !== want.cursor)
                        report_mismatch($sformatf("cursor_position %0d, expected %0d",
                                                  cursor_position, want.cursor));
                    if (scrolled !== want.scrolled)
                        report_mismatch($sformatf("scrolled %b, expected %b",
                                                  scrolled, want.scrolled));
                    if (cell_character !== want.ch)
                        report_mismatch($sformatf("cell_character %h, expected %h",
                                                  cell_character, want.ch));
                    if (cell_attribute !== want.attr)
                        report_mismatch($sformatf("cell_attribute %h, expected %h",
                                                  cell_attribute, want.attr));
                end
            end
            if (start && !busy)
            begin
                run_console_command(tcw_cmd_t'(command), character, column, screen_row,
                                    attribute, want);
                expected_beats.push_back(want);
                if (command == CMD_READ)
                    read_count++;
            end
            if (psel && penable && pready && paddr == ATTR_REG_ADDR)
            begin
                if (pwrite)
                    default_attr = pwdata[ATTR_W-1:0];
                else if (prdata[ATTR_W-1:0] !== default_attr)
                    report_mismatch($sformatf("default attribute read %h, expected %h",
                                              prdata[ATTR_W-1:0], default_attr));
            end
        end
        pending <= expected_beats.size();
        failures <= fail_count;
        beats <= beat_count;
        scroll_beats <= scroll_count;
        read_beats <= read_count;
    end

endmodule

// ===== tb/text_console_writer_core_tb.sv =====
module text_console_writer_core_tb;
    import tcw_pkg::*;

    localparam int CYCLE_LIMIT = 13_000_000;
    localparam int PHASE_ITEMS = 250;
    localparam int PHASES = 6;
    localparam logic [CFG_ADDR_W-1:0] ATTR_REG_ADDR = CFG_ADDR_W'(4 * REG_DEFAULT_ATTRIBUTE);

    logic                  clk;
    logic                  rst_n;
    logic                  start;
    logic                  busy;
    tcw_cmd_t              command;
    logic [CHAR_W-1:0]     character;
    logic signed [7:0]     column;
    logic signed [5:0]     screen_row;
    logic [ATTR_W-1:0]     attribute;
    logic                  done;
    logic [CURSOR_W-1:0]   cursor_position;
    logic                  scrolled;
    logic [CHAR_W-1:0]     cell_character;
    logic [ATTR_W-1:0]     cell_attribute;
    logic                  psel;
    logic                  penable;
    logic                  pwrite;
    logic [CFG_ADDR_W-1:0] paddr;
    logic [31:0]           pwdata;
    logic [31:0]           prdata;
    logic                  pready;

    int   failures;
    int   pending;
    int   beats;
    int   scroll_beats;
    int   read_beats;
    int   cycle_count = 0;
    int   commands_sent = 0;
    int   settings_used = 1;
    logic no_gaps = 1'b0;

    text_console_writer_core uut (
        .clk             (clk),
        .rst_n           (rst_n),
        .start           (start),
        .busy            (busy),
        .command         (command),
        .character       (character),
        .column          (column),
        .screen_row      (screen_row),
        .attribute       (attribute),
        .done            (done),
        .cursor_position (cursor_position),
        .scrolled        (scrolled),
        .cell_character  (cell_character),
        .cell_attribute  (cell_attribute),
        .psel            (psel),
        .penable         (penable),
        .pwrite          (pwrite),
        .paddr           (paddr),
        .pwdata          (pwdata),
        .prdata          (prdata),
        .pready          (pready)
    );

    text_console_writer_core_checker console_checker (
        .clk             (clk),
        .rst_n           (rst_n),
        .start           (start),
        .busy            (busy),
        .command         (command),
        .character       (character),
        .column          (column),
        .screen_row      (screen_row),
        .attribute       (attribute),
        .done            (done),
        .cursor_position (cursor_position),
        .scrolled        (scrolled),
        .cell_character  (cell_character),
        .cell_attribute  (cell_attribute),
        .psel            (psel),
        .penable         (penable),
        .pwrite          (pwrite),
        .paddr           (paddr),
        .pwdata          (pwdata),
        .prdata          (prdata),
        .pready          (pready),
        .failures        (failures),
        .pending         (pending),
        .beats           (beats),
        .scroll_beats    (scroll_beats),
        .read_beats      (read_beats)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("Timed out with %0d beats outstanding.", pending);
            $display("text_console_writer_core test failed");
            $finish;
        end
    end

    task automatic send_command(
        input tcw_cmd_t          cmd,
        input logic [CHAR_W-1:0] ch,
        input logic signed [7:0] col,
        input logic signed [5:0] row,
        input logic [ATTR_W-1:0] attr
    );
        int gap;
        gap = no_gaps ? 0 : $urandom_range(0, 18);
        if (gap > 0)
        begin
            start <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        start <= 1'b1;
        command <= cmd;
        character <= ch;
        column <= col;
        screen_row <= row;
        attribute <= attr;
        @(posedge clk);
        while (busy)
            @(posedge clk);
        commands_sent++;
    endtask

    task automatic wait_idle();
        start <= 1'b0;
        @(posedge clk);
        while (pending != 0 || busy)
            @(posedge clk);
    endtask

    task automatic cfg_access(input logic wr, input logic [ATTR_W-1:0] value);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= wr;
        paddr <= ATTR_REG_ADDR;
        pwdata <= 32'(value);
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        psel <= 1'b0;
        penable <= 1'b0;
        @(posedge clk);
    endtask

    task automatic send_random_command();
        tcw_cmd_t          cmd;
        logic [CHAR_W-1:0] ch;
        logic [ATTR_W-1:0] attr;
        logic signed [7:0] col;
        logic signed [5:0] row;
        int                pick;
        cmd = ($urandom_range(0, 99) < 30) ? CMD_READ : CMD_PRINT;
        ch = ($urandom_range(0, 99) < 8) ? NEWLINE_CODE : CHAR_W'($urandom_range(0, 255));
        attr = ($urandom_range(0, 99) < 20) ? '0 : ATTR_W'($urandom_range(0, 255));
        pick = $urandom_range(0, 99);
        if (pick < 20)
        begin
            col = 8'($urandom_range(128, 255));
            row = 6'($urandom_range(0, 63));
        end
        else if (pick < 35)
        begin
            col = 8'($urandom_range(0, 255));
            row = 6'($urandom_range(32, 63));
        end
        else if (pick < 45)
        begin
            if ($urandom_range(0, 1) == 0)
            begin
                col = 8'($urandom_range(COLUMNS, 127));
                row = 6'($urandom_range(0, 31));
            end
            else
            begin
                col = 8'($urandom_range(0, 127));
                row = 6'($urandom_range(ROWS, 31));
            end
        end
        else
        begin
            col = ($urandom_range(0, 4) == 0) ? 8'(COLUMNS - 1) : 8'($urandom_range(0, COLUMNS - 1));
            row = ($urandom_range(0, 3) == 0) ? 6'(ROWS - 1) : 6'($urandom_range(0, ROWS - 1));
        end
        send_command(cmd, ch, col, row, attr);
    endtask

    initial
    begin
        logic [ATTR_W-1:0] setting;
        start <= 1'b0;
        command <= CMD_PRINT;
        character <= '0;
        column <= '0;
        screen_row <= '0;
        attribute <= '0;
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
        paddr <= '0;
        pwdata <= '0;
        rst_n <= 1'b0;
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        wait_idle();
        cfg_access(1'b0, '0);

        send_command(CMD_PRINT, 8'd65, 8'sd0, 6'sd0, 8'h00);
        send_command(CMD_READ, 8'd0, 8'sd0, 6'sd0, 8'h00);
        send_command(CMD_PRINT, 8'hFF, 8'sd79, 6'sd0, 8'hFF);
        send_command(CMD_PRINT, 8'h00, -8'sd1, -6'sd1, 8'h01);
        send_command(CMD_READ, 8'hFF, -8'sd128, 6'sd5, 8'hFF);
        send_command(CMD_PRINT, 8'd66, 8'sd80, 6'sd0, 8'h22);
        send_command(CMD_PRINT, 8'd67, 8'sd127, 6'sd31, 8'h33);
        send_command(CMD_PRINT, 8'd68, 8'sd0, 6'sd25, 8'h44);
        send_command(CMD_READ, 8'd0, 8'sd127, 6'sd31, 8'h00);
        send_command(CMD_READ, 8'd0, 8'sd79, 6'sd0, 8'h00);
        send_command(CMD_PRINT, NEWLINE_CODE, 8'sd10, 6'sd3, 8'h00);
        send_command(CMD_PRINT, 8'd120, 8'sd5, -6'sd1, 8'h00);
        send_command(CMD_PRINT, 8'h55, 8'sd0, -6'sd32, 8'h7E);
        send_command(CMD_PRINT, NEWLINE_CODE, -8'sd1, -6'sd1, 8'h12);
        send_command(CMD_PRINT, NEWLINE_CODE, 8'sd0, 6'sd24, 8'h00);
        send_command(CMD_READ, 8'd0, 8'sd0, 6'sd23, 8'h00);
        send_command(CMD_PRINT, 8'hAA, 8'sd79, 6'sd24, 8'h55);
        send_command(CMD_READ, 8'd0, 8'sd79, 6'sd23, 8'h00);
        send_command(CMD_READ, 8'd0, -8'sd1, -6'sd1, 8'h00);
        send_command(CMD_PRINT, 8'd49, 8'sd78, 6'sd24, 8'h00);
        send_command(CMD_PRINT, 8'd50, -8'sd1, -6'sd1, 8'h00);
        send_command(CMD_READ, 8'd0, 8'sd78, 6'sd23, 8'h00);
        send_command(CMD_READ, 8'd0, 8'sd79, 6'sd23, 8'h00);

        for (int p = 0; p < PHASES; p++)
        begin
            wait_idle();
            case (p)
                0: setting = 8'h00;
                1: setting = 8'hFF;
                2: setting = 8'h80;
                3: setting = 8'h01;
                default: setting = ATTR_W'($urandom_range(1, 254));
            endcase
            cfg_access(1'b1, setting);
            cfg_access(1'b0, '0);
            settings_used++;
            for (int n = 0; n < PHASE_ITEMS; n++)
            begin
                if (n % 50 == 0)
                    no_gaps = ($urandom_range(0, 3) == 0);
                send_random_command();
            end
        end

        wait_idle();
        repeat (8) @(posedge clk);
        $display("Sent %0d commands and checked %0d result beats (%0d reads, %0d scrolls).",
                 commands_sent, beats, read_beats, scroll_beats);
        $display("Default attribute took %0d settings, including 0 and 255.", settings_used);
        if (failures == 0)
            $display("text_console_writer_core test passed");
        else
            $display("text_console_writer_core test failed");
        $finish;
    end

endmodule
